[rtl/core/sdt_pkg.sv]
// Shared types and constants for the sound dip trigger detector.
// No dependencies; every other file of the block imports this package.
package sdt_pkg;

  localparam int unsigned SENS_W     = 7;
  localparam logic [SENS_W-1:0] SENS_RESET = 7'd10;
  localparam int unsigned PCT_W      = 7;
  localparam logic [PCT_W-1:0] PERCENT = 7'd100;

  // Control from the sequencer to the sample window.
  typedef struct packed {
    logic rd_en;   // read the slot about to be overwritten
    logic upd_en;  // write the new sample and update the running sum
  } sdt_win_ctrl_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_LOAD = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

endpackage

[rtl/core/sdt_window.sv]
// Sample ring with write slot, fill flag and running sum.
// Depends on sdt_pkg for the control struct.
module sdt_window import sdt_pkg::*; #(
  parameter int unsigned DEPTH       = 10,
  parameter int unsigned SAMPLE_BITS = 10,
  parameter int unsigned SUM_W       = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sdt_win_ctrl_t          ctrl_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic [SUM_W-1:0]       sum_o,
  output logic                   full_o
);

  localparam int unsigned SLOT_W = $clog2(DEPTH);

  logic [SAMPLE_BITS-1:0] mem_q [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_q;
  logic [SLOT_W-1:0]      slot_q, slot_d;
  logic                   full_q, full_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic                   wrap;

  assign wrap = (slot_q == SLOT_W'(DEPTH - 1));

  always_comb begin
    slot_d = slot_q;
    full_d = full_q;
    sum_d  = sum_q;
    if (ctrl_i.upd_en) begin
      // The evicted sample only counts once the ring has wrapped.
      if (full_q) begin
        sum_d = sum_q - SUM_W'(rd_q) + SUM_W'(sample_i);
      end else begin
        sum_d = sum_q + SUM_W'(sample_i);
      end
      if (wrap) begin
        slot_d = '0;
        full_d = 1'b1;
      end else begin
        slot_d = slot_q + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      full_q <= 1'b0;
      sum_q  <= '0;
    end else begin
      slot_q <= slot_d;
      full_q <= full_d;
      sum_q  <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_q <= mem_q[slot_q];
    end
    if (ctrl_i.upd_en) begin
      mem_q[slot_q] <= sample_i;
    end
  end

  assign sum_o  = sum_q;
  assign full_o = full_q;

endmodule

[rtl/core/sdt_serdiv.sv]
// Bit-serial restoring divider by a constant: one quotient bit per cycle.
// Depends on sdt_pkg only through the common import convention.
module sdt_serdiv import sdt_pkg::*; #(
  parameter int unsigned N_W     = 14,
  parameter int unsigned DIVISOR = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] dividend_i,
  output logic           done_o,
  output logic [N_W-1:0] quotient_o
);

  localparam int unsigned R_W   = $clog2(DIVISOR) + 1;
  localparam int unsigned CNT_W = $clog2(N_W + 1);

  logic [N_W-1:0]   dvd_q, dvd_d;
  logic [R_W-1:0]   rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [R_W-1:0]   trial;
  logic             fits;

  // The remainder stays below the divisor, so its top bit is always clear.
  assign trial = {rem_q[R_W-2:0], dvd_q[N_W-1]};
  assign fits  = (trial >= R_W'(DIVISOR));

  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (start_i) begin
      dvd_d = dividend_i;
      rem_d = '0;
      cnt_d = CNT_W'(N_W);
    end else if (cnt_q != '0) begin
      // Dividend bits leave at the top while quotient bits enter at the bottom.
      dvd_d = {dvd_q[N_W-2:0], fits};
      rem_d = fits ? (trial - R_W'(DIVISOR)) : trial;
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o     = (cnt_q == '0);
  assign quotient_o = dvd_q;

endmodule

[rtl/core/sound_dip_trigger_detector_top.sv]
// Top level of the sound dip trigger detector: sequencer, threshold test, result register.
// Depends on sdt_pkg, sdt_window and sdt_serdiv.
//
// Each accepted sample beat is stored in a ring of WINDOW_DEPTH entries and
// produces exactly one result beat. Once the ring has filled, the result carries
// the truncated mean of the stored samples and fires triggered when the mean
// exceeds the sample by more than the sensitivity percentage; before that,
// average and triggered are zero. Each sample goes through the read, load, divide,
// multiply and output states before the next one is accepted; the serial divider
// yields one bit of the mean per cycle. A finished result waits in its own register,
// so the next sample can be taken while it is still pending. The user must write
// sensitivity with cfg_we_i only while the block is idle; the block itself does
// not enforce this. Values above 100 never fire.
module sound_dip_trigger_detector_top import sdt_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 10,
  parameter int unsigned SAMPLE_BITS  = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [SENS_W-1:0]      cfg_wdata_i,
  input  logic                   sample_valid_i,
  output logic                   sample_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   result_valid_o,
  input  logic                   result_ready_i,
  output logic                   triggered_o,
  output logic [SAMPLE_BITS-1:0] average_o,
  output logic                   ready_res_o
);

  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int unsigned PROD_W = SAMPLE_BITS + SENS_W + 1;

  state_e state_q, state_d;

  logic [SENS_W-1:0]      sens_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   accept;
  sdt_win_ctrl_t          win_ctrl;
  logic [SUM_W-1:0]       win_sum;
  logic                   win_full;
  logic                   div_start;
  logic                   div_done;
  logic [SUM_W-1:0]       quotient;
  logic [SAMPLE_BITS-1:0] avg;

  logic                   above_q;
  logic [PROD_W-1:0]      dip_q;
  logic [PROD_W-1:0]      limit_q;
  logic                   fire;
  logic                   out_free;

  logic                   res_valid_q;
  logic                   res_trig_q;
  logic [SAMPLE_BITS-1:0] res_avg_q;
  logic                   res_full_q;

  assign accept    = sample_valid_i && (state_q == ST_IDLE);
  assign out_free  = !res_valid_q || result_ready_i;
  assign div_start = (state_q == ST_LOAD);

  assign win_ctrl.rd_en  = accept;
  assign win_ctrl.upd_en = (state_q == ST_READ);

  sdt_window #(
    .DEPTH       (WINDOW_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (win_ctrl),
    .sample_i (sample_q),
    .sum_o    (win_sum),
    .full_o   (win_full)
  );

  sdt_serdiv #(
    .N_W     (SUM_W),
    .DIVISOR (WINDOW_DEPTH)
  ) u_serdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (win_sum),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign avg = quotient[SAMPLE_BITS-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (sample_valid_i) state_d = ST_READ;
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_MUL;
      ST_MUL:  state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sens_q  <= SENS_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        sens_q <= cfg_wdata_i;
      end
    end
  end

  // floor(dip * 100 / avg) > sens holds exactly when dip * 100 >= (sens + 1) * avg,
  // which avoids dividing by the mean.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
    end
    if (state_q == ST_MUL) begin
      above_q <= (avg > sample_q);
      dip_q   <= PROD_W'(avg - sample_q) * PROD_W'(PERCENT);
      limit_q <= (PROD_W'(sens_q) + PROD_W'(1)) * PROD_W'(avg);
    end
  end

  assign fire = win_full && above_q && (dip_q >= limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if ((state_q == ST_OUT) && out_free) begin
      res_valid_q <= 1'b1;
    end else if (result_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_OUT) && out_free) begin
      res_trig_q <= fire;
      res_avg_q  <= win_full ? avg : '0;
      res_full_q <= win_full;
    end
  end

  assign sample_ready_o = (state_q == ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign triggered_o    = res_trig_q;
  assign average_o      = res_avg_q;
  assign ready_res_o    = res_full_q;

endmodule
